// ----- hw/rtl/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths, sequencer states and status types for the trial division
// prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_W = 32;
    localparam int DIV_W   = 16;
    localparam int SQ_W    = 32;
    localparam int CNT_W   = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

// ----- hw/rtl/tdpt_rem_unit.sv -----
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle, reports
// whether the divisor divides the dividend evenly.
// ----------------------------------------------------------------------------
module tdpt_rem_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tdpt_pkg::VALUE_W-1:0] dividend,
    input  logic [tdpt_pkg::DIV_W-1:0] divisor,
    output tdpt_pkg::rem_status_t      status
);
    import tdpt_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    logic               done_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [VALUE_W-1:0] dvd_reg;
    logic [VALUE_W-1:0] dvd_next;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   rem_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;
    logic               fits;

    assign trial = {rem_reg, dvd_reg[VALUE_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = !diff[DIV_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            dvd_next = {dvd_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Values below 2 go straight to a non-prime result; otherwise divisors are
// tried, up to 46339 of them for the largest positive prime. One item at a
// time: each divisor takes a bound check plus a pass of the bit-serial
// remainder unit; the next item can be taken in the cycle after the result
// loads the output register. Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Trial division primality test of signed 32-bit values with a pass-through
// array end flag, one result item per input item.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [tdpt_pkg::VALUE_W-1:0] value,
    input  logic                              last_of_array,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [tdpt_pkg::VALUE_W-1:0] tested_value,
    output logic                              is_prime,
    output logic                              last_out
);
    import tdpt_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [VALUE_W-1:0] n_reg;
    logic [VALUE_W-1:0] n_next;
    logic               last_reg;
    logic               last_next;
    logic [DIV_W-1:0]   d_reg;
    logic [DIV_W-1:0]   d_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    sq_next;
    logic               prime_reg;
    logic               prime_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_prime_reg;
    logic               out_last_reg;
    logic               accept;
    logic               start;
    logic               out_load;
    logic               small_value;
    logic               over_bound;
    rem_status_t        rem_status;

    assign accept      = in_valid && !in_stall;
    assign small_value = (value < VALUE_W'(signed'(2)));
    assign over_bound  = (sq_reg > SQ_W'(n_reg));

    tdpt_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = small_value ? S_DONE : S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = over_bound ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (rem_status.done)
                begin
                    state_next = rem_status.zero ? S_DONE : S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        start    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_CHECK: start    = !over_bound;
            S_DIV:   start    = 1'b0;
            S_DONE:  out_load = !out_valid_reg || !out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    // datapath
    always_comb
    begin
        n_next     = n_reg;
        last_next  = last_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        if (accept)
        begin
            n_next     = value;
            last_next  = last_of_array;
            d_next     = DIV_W'(2);
            sq_next    = SQ_W'(4);
            prime_next = 1'b0;
        end
        else if (state_reg == S_CHECK && over_bound)
        begin
            prime_next = 1'b1;
        end
        else if (state_reg == S_DIV && rem_status.done)
        begin
            if (rem_status.zero)
            begin
                prime_next = 1'b0;
            end
            else
            begin
                d_next  = d_reg + DIV_W'(1);
                sq_next = sq_reg + SQ_W'({d_reg, 1'b1});
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        last_reg  <= last_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
        if (out_load)
        begin
            out_value_reg <= n_reg;
            out_prime_reg <= prime_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tested_value = out_value_reg;
    assign is_prime     = out_prime_reg;
    assign last_out     = out_last_reg;

endmodule

// ----- hw/rtl/tdpt_checker.sv -----
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks for the trial division prime test, bound to the top.
// ----------------------------------------------------------------------------
module tdpt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic signed [tdpt_pkg::VALUE_W-1:0] value,
    input logic                              last_of_array,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [tdpt_pkg::VALUE_W-1:0] tested_value,
    input logic                              is_prime,
    input logic                              last_out
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tested_value) && $stable(is_prime)
            && $stable(last_out))
        else $error("stalled result item changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken before test finished");

    a_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_prime |-> !tested_value[31] && tested_value[30:1] != 30'd0)
        else $error("value below 2 flagged prime");

    a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_prime |-> tested_value[0] || tested_value == 32'sd2)
        else $error("even value above 2 flagged prime");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);
